>>> hdl/bffa_pkg.sv
// Package for the bitmap first-fit allocator.
// Holds the map geometry, the opcode, register and state codes, and the shared structs.
// No dependencies.
package bffa_pkg;

	// Map geometry
	localparam int MAP_BITS   = 4096;
	localparam int WORD_BITS  = 32;
	localparam int INDEX_W    = 12;
	localparam int INDEX_SPAN = 1 << INDEX_W;

	// Only bits below the index span can be reached
	localparam int REACH_BITS = (MAP_BITS < INDEX_SPAN) ? MAP_BITS : INDEX_SPAN;
	localparam int MAP_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int LAST_WORD  = (REACH_BITS - 1) / WORD_BITS;
	localparam int LAST_BIT   = (REACH_BITS - 1) % WORD_BITS;

	// Both maps share one word store, map select is the top address bit
	localparam int RAM_ADDR_W = WORD_IDX_W + 1;
	localparam int RAM_DEPTH  = 1 << RAM_ADDR_W;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_CLR   = 2'd1,
		OP_TEST  = 2'd2,
		OP_ALLOC = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INODE_START = 1'b0,
		CFG_DATA_START  = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic                  en;
		logic [RAM_ADDR_W-1:0] addr;
		word_t                 data;
	} ram_wr_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] pos;
	} fz_res_t;

endpackage

>>> hdl/bitmap_first_fit_allocator.sv
// Bitmap first-fit allocator: inode and data-block maps with set, clear, test and allocate.
// Sequence, accept to result: set, clear and test go through read, execute and done; allocate
// through read, a scan over up to 128 reachable words, and done; out-of-range requests go to done.
// The next request is taken once the sequencer is back in idle; allocate time is set by
// the one-word-per-cycle scan through the bitmap RAM read port and the shared search unit.
// Reset: both maps read as free at once (per-word valid flags); start bits reset to 1 and 0.
module bitmap_first_fit_allocator
	import bffa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic                  map_select,
	input  logic [INDEX_W-1:0]    bit_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  bit_value,
	output logic [INDEX_W-1:0]    alloc_index,
	output logic                  alloc_found
);

	state_t                state_q, state_d;
	op_t                   op_q;
	logic                  map_q;
	logic [INDEX_W-1:0]    idx_q;
	logic [WORD_IDX_W-1:0] word_q;
	logic                  first_q;
	logic                  res_bv_q, res_af_q;
	logic [INDEX_W-1:0]    res_ai_q;
	logic [INDEX_W-1:0]    inode_start_q, data_start_q;
	logic                  out_vld_q, bv_q, af_q;
	logic [INDEX_W-1:0]    ai_q;

	logic                  in_acc;
	logic [INDEX_W-1:0]    idx_src;
	logic                  in_range;
	logic [WORD_IDX_W-1:0] word_nx;
	logic                  last_word;
	logic [BIT_W-1:0]      bit_pos, scan_lo, scan_hi;
	logic                  rd_en, scan_adv, found_now, test_now, load_out;
	logic [RAM_ADDR_W-1:0] rd_addr;
	word_t                 rd_data;
	ram_wr_t               wr;
	fz_res_t               fz;

	// Request decode
	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign idx_src  = (op_t'(opcode) == OP_ALLOC) ?
		(map_select ? data_start_q : inode_start_q) : bit_index;
	assign in_range = {1'b0, idx_src} < (INDEX_W + 1)'(REACH_BITS);

	assign word_nx   = word_q + WORD_IDX_W'(1);
	assign last_word = (word_q == WORD_IDX_W'(LAST_WORD));
	assign bit_pos   = BIT_W'(idx_q % WORD_BITS);
	assign scan_lo   = first_q ? bit_pos : '0;
	assign scan_hi   = last_word ? BIT_W'(LAST_BIT) : BIT_W'(WORD_BITS - 1);

	bffa_word_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bffa_find_zero u_fz (
		.word (rd_data),
		.lo   (scan_lo),
		.hi   (scan_hi),
		.res  (fz)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM access and datapath strobes
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = {map_q, word_q};
		wr        = '0;
		wr.addr   = {map_q, word_q};
		scan_adv  = 1'b0;
		found_now = 1'b0;
		test_now  = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = in_range ? ST_READ : ST_DONE;
				end
			end
			ST_READ: begin
				rd_en   = 1'b1;
				state_d = (op_q == OP_ALLOC) ? ST_SCAN : ST_EXEC;
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				unique case (op_q)
					OP_SET: begin
						wr.en   = 1'b1;
						wr.data = rd_data | (word_t'(1) << bit_pos);
					end
					OP_CLR: begin
						wr.en   = 1'b1;
						wr.data = rd_data & ~(word_t'(1) << bit_pos);
					end
					OP_TEST:  test_now = 1'b1;
					OP_ALLOC: ;
					default: ;
				endcase
			end
			ST_SCAN: begin
				if (fz.found) begin
					// Claim the free bit and finish
					found_now = 1'b1;
					wr.en     = 1'b1;
					wr.data   = rd_data | (word_t'(1) << fz.pos);
					state_d   = ST_DONE;
				end else if (last_word) begin
					state_d = ST_DONE;
				end else begin
					// Fetch the next word while this one is checked
					scan_adv = 1'b1;
					rd_en    = 1'b1;
					rd_addr  = {map_q, word_nx};
				end
			end
			ST_DONE: begin
				if (!out_vld_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Request and result registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= op_t'(opcode);
			map_q    <= map_select;
			idx_q    <= idx_src;
			word_q   <= WORD_IDX_W'(idx_src / WORD_BITS);
			first_q  <= 1'b1;
			res_bv_q <= 1'b0;
			res_af_q <= 1'b0;
			res_ai_q <= '0;
		end else begin
			if (scan_adv) begin
				word_q  <= word_nx;
				first_q <= 1'b0;
			end
			if (test_now) begin
				res_bv_q <= rd_data[bit_pos];
			end
			if (found_now) begin
				res_af_q <= 1'b1;
				res_ai_q <= INDEX_W'(int'(word_q) * WORD_BITS + int'(fz.pos));
			end
		end
		if (load_out) begin
			bv_q <= res_bv_q;
			ai_q <= res_ai_q;
			af_q <= res_af_q;
		end
	end

	// Output beat valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// Search start registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_start_q <= INDEX_W'(1);
			data_start_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_INODE_START: inode_start_q <= cfg_data;
				CFG_DATA_START:  data_start_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_valid   = out_vld_q;
	assign bit_value   = bv_q;
	assign alloc_index = ai_q;
	assign alloc_found = af_q;

	// Bitmap writes happen only while a request executes
	a_wr_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_EXEC || state_q == ST_SCAN))
		else $error("bitmap write outside execute");

	// The scan never runs past the last reachable word
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (word_q <= WORD_IDX_W'(LAST_WORD)))
		else $error("scan beyond last word");

	// A finished request shows up on the output in the next cycle
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid && (state_q == ST_IDLE)))
		else $error("finished request not presented");

	// A test result and an allocation never share one beat
	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(bit_value && alloc_found))
		else $error("test and allocate results mixed");

endmodule

>>> hdl/bffa_word_ram.sv
// Bitmap word store for both maps, one write and one registered read per cycle.
// Per-word valid flags make never-written words read as all free.
// Depends on bffa_pkg.
module bffa_word_ram
	import bffa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ram_wr_t               wr,
	input  logic                  rd_en,
	input  logic [RAM_ADDR_W-1:0] rd_addr,
	output word_t                 rd_data
);

	word_t                mem_q [RAM_DEPTH];
	logic [RAM_DEPTH-1:0] vld_q;
	word_t                rd_q;
	logic                 rd_vld_q;

	// Word storage and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Valid flags: cleared at reset, set by the first write to a word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// Unwritten words read as all free
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

>>> hdl/bffa_find_zero.sv
// Shared search unit: lowest clear bit of one bitmap word within a bit window.
// Depends on bffa_pkg.
module bffa_find_zero
	import bffa_pkg::*;
(
	input  word_t            word,
	input  logic [BIT_W-1:0] lo,
	input  logic [BIT_W-1:0] hi,
	output fz_res_t          res
);

	// Priority encode from the top so the lowest free bit wins
	always_comb begin
		res = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i] && (BIT_W'(i) >= lo) && (BIT_W'(i) <= hi)) begin
				res.found = 1'b1;
				res.pos   = BIT_W'(i);
			end
		end
	end

endmodule

>>> tb/sv/bitmap_first_fit_allocator_tb.sv
`timescale 1ns / 1ps
// Testbench for the bitmap first-fit allocator: directed and random set, clear, test and
// allocate requests, checked beat by beat against a bit-level model of both maps.
// Depends on bffa_pkg and the bitmap_first_fit_allocator top level.
module bitmap_first_fit_allocator_tb;
	import bffa_pkg::*;

	typedef enum {PLAN_REQ, PLAN_CFG, PLAN_DRAIN, PLAN_PACE} plan_kind_t;

	typedef struct {
		plan_kind_t            kind;
		op_t                   op;
		logic                  sel;
		logic [INDEX_W-1:0]    idx;
		cfg_reg_t              reg_id;
		logic [CFG_DATA_W-1:0] reg_val;
		int unsigned           send_idle_pct;
		int unsigned           recv_stall_pct;
	} plan_entry_t;

	typedef struct packed {
		logic               bit_value;
		logic [INDEX_W-1:0] alloc_index;
		logic               alloc_found;
	} reply_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            opcode = OP_TEST;
	logic                  map_select = 1'b0;
	logic [INDEX_W-1:0]    bit_index = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  bit_value;
	logic [INDEX_W-1:0]    alloc_index;
	logic                  alloc_found;

	plan_entry_t request_plan[$];
	reply_t      awaited_replies[$];

	// Model of both maps and the search start registers
	bit                 map_used [2][MAP_BITS];
	logic [INDEX_W-1:0] inode_start_copy = 12'd1;
	logic [INDEX_W-1:0] data_start_copy = 12'd0;

	logic        beat_taken = 1'b0;
	logic        stim_done = 1'b0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatch_count = 0;
	int unsigned error_count = 0;

	bitmap_first_fit_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.map_select (map_select),
		.bit_index  (bit_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bit_value  (bit_value),
		.alloc_index(alloc_index),
		.alloc_found(alloc_found)
	);

	always #4 clk = ~clk;

	// Apply one request to the model maps and queue the reply it should produce
	function automatic void apply_map_request(op_t op, logic sel, logic [INDEX_W-1:0] idx);
		reply_t      r;
		int unsigned b;
		r = '0;
		case (op)
			OP_SET: begin
				if (idx < REACH_BITS) map_used[sel][idx] = 1'b1;
			end
			OP_CLR: begin
				if (idx < REACH_BITS) map_used[sel][idx] = 1'b0;
			end
			OP_TEST: begin
				if (idx < REACH_BITS) r.bit_value = map_used[sel][idx];
			end
			default: begin
				// First fit upward from the start bit; bits below it are never looked at
				b = sel ? data_start_copy : inode_start_copy;
				while (b < REACH_BITS && !r.alloc_found) begin
					if (!map_used[sel][b]) begin
						map_used[sel][b] = 1'b1;
						r.alloc_index = b[INDEX_W-1:0];
						r.alloc_found = 1'b1;
					end
					b++;
				end
			end
		endcase
		awaited_replies.push_back(r);
	endfunction

	function automatic void plan_request(op_t op, logic sel, logic [INDEX_W-1:0] idx);
		plan_entry_t e;
		e = '{default: 0, kind: PLAN_REQ, op: op, reg_id: CFG_INODE_START};
		e.sel = sel;
		e.idx = idx;
		request_plan.push_back(e);
	endfunction

	// Drain first so registers only change while the block is idle
	function automatic void plan_starts(logic [CFG_DATA_W-1:0] inode_s,
			logic [CFG_DATA_W-1:0] data_s);
		plan_entry_t e;
		e = '{default: 0, kind: PLAN_DRAIN, op: OP_TEST, reg_id: CFG_INODE_START};
		request_plan.push_back(e);
		e.kind = PLAN_CFG;
		e.reg_val = inode_s;
		request_plan.push_back(e);
		e.reg_id = CFG_DATA_START;
		e.reg_val = data_s;
		request_plan.push_back(e);
	endfunction

	function automatic void plan_pace(int unsigned send_pct, int unsigned recv_pct);
		plan_entry_t e;
		e = '{default: 0, kind: PLAN_PACE, op: OP_TEST, reg_id: CFG_INODE_START};
		e.send_idle_pct = send_pct;
		e.recv_stall_pct = recv_pct;
		request_plan.push_back(e);
	endfunction

	// Bias indices toward the search start so allocations and holes collide
	function automatic logic [INDEX_W-1:0] pick_index(int unsigned near);
		int unsigned roll;
		int unsigned v;
		roll = $urandom_range(99);
		if (roll < 45) v = $urandom_range(4095);
		else if (roll < 85) v = near + $urandom_range(160);
		else v = $urandom_range(63);
		if (v > 4095) v = 4095;
		return v[INDEX_W-1:0];
	endfunction

	// Driver: hand out request beats, register writes and drains; pace both sides
	always @(negedge clk) begin
		logic                  nx_valid;
		logic                  nx_we;
		logic [1:0]            nx_op;
		logic                  nx_sel;
		logic [INDEX_W-1:0]    nx_idx;
		logic [CFG_IDX_W-1:0]  nx_reg;
		logic [CFG_DATA_W-1:0] nx_val;
		nx_valid = in_valid;
		nx_we = 1'b0;
		nx_op = opcode;
		nx_sel = map_select;
		nx_idx = bit_index;
		nx_reg = cfg_index;
		nx_val = cfg_data;
		if (in_valid && beat_taken) nx_valid = 1'b0;
		if (arst_n && !nx_valid && !stim_done) begin
			if (request_plan.size() == 0) begin
				stim_done <= 1'b1;
			end else begin
				case (request_plan[0].kind)
					PLAN_REQ: begin
						if ($urandom_range(99) >= send_idle_pct) begin
							nx_valid = 1'b1;
							nx_op = request_plan[0].op;
							nx_sel = request_plan[0].sel;
							nx_idx = request_plan[0].idx;
							void'(request_plan.pop_front());
						end
					end
					PLAN_CFG: begin
						nx_we = 1'b1;
						nx_reg = request_plan[0].reg_id;
						nx_val = request_plan[0].reg_val;
						void'(request_plan.pop_front());
					end
					PLAN_DRAIN: begin
						// Hold off until every reply is in, then let the block settle
						if (awaited_replies.size() == 0) begin
							quiet_cycles++;
							if (quiet_cycles >= 8) begin
								quiet_cycles = 0;
								void'(request_plan.pop_front());
							end
						end else begin
							quiet_cycles = 0;
						end
					end
					default: begin
						send_idle_pct = request_plan[0].send_idle_pct;
						recv_stall_pct = request_plan[0].recv_stall_pct;
						void'(request_plan.pop_front());
					end
				endcase
			end
		end
		in_valid <= nx_valid;
		cfg_we <= nx_we;
		opcode <= nx_op;
		map_select <= nx_sel;
		bit_index <= nx_idx;
		cfg_index <= nx_reg;
		cfg_data <= nx_val;
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Monitor: track register writes and accepted requests, check each reply beat
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		beat_taken = in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_INODE_START) inode_start_copy = cfg_data;
				else if (cfg_index == CFG_DATA_START) data_start_copy = cfg_data;
			end
			if (beat_taken) apply_map_request(op_t'(opcode), map_select, bit_index);
			if (out_valid && !out_stall) begin
				got = '{bit_value, alloc_index, alloc_found};
				if (awaited_replies.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected reply: bv=%0d idx=%0d found=%0d",
							got.bit_value, got.alloc_index, got.alloc_found);
				end else begin
					want = awaited_replies.pop_front();
					if (got !== want) begin
						mismatch_count++;
						error_count++;
						if (mismatch_count <= 10) begin
							$display("reply mismatch: expected bv=%0d idx=%0d found=%0d",
								want.bit_value, want.alloc_index, want.alloc_found);
							$display("                got      bv=%0d idx=%0d found=%0d",
								got.bit_value, got.alloc_index, got.alloc_found);
						end
					end
				end
			end
		end
	end

	initial begin
		int unsigned inode_s [8];
		int unsigned data_s [8];
		int unsigned sel;
		int unsigned roll;
		op_t         op;

		// Directed: reset starts, index zero, top bit, full from start bit
		plan_pace(0, 0);
		plan_request(OP_ALLOC, 1'b0, 12'd0);
		plan_request(OP_ALLOC, 1'b1, 12'd0);
		plan_request(OP_TEST, 1'b0, 12'd0);
		plan_request(OP_TEST, 1'b0, 12'd1);
		plan_request(OP_SET, 1'b0, 12'd0);
		plan_request(OP_ALLOC, 1'b0, 12'hFFF);
		plan_request(OP_SET, 1'b1, 12'hFFF);
		plan_request(OP_TEST, 1'b1, 12'hFFF);
		plan_request(OP_CLR, 1'b1, 12'hFFF);
		plan_request(OP_TEST, 1'b1, 12'hFFF);
		plan_request(OP_SET, 1'b0, 12'hAAA);
		plan_request(OP_TEST, 1'b0, 12'h555);
		plan_request(OP_TEST, 1'b0, 12'hAAA);
		plan_request(OP_CLR, 1'b0, 12'd1);
		plan_request(OP_ALLOC, 1'b0, 12'd0);
		plan_starts(12'hFFF, 12'hFFE);
		plan_request(OP_ALLOC, 1'b0, 12'd0);
		plan_request(OP_ALLOC, 1'b0, 12'd0);
		plan_request(OP_SET, 1'b1, 12'hFFE);
		plan_request(OP_ALLOC, 1'b1, 12'd0);
		plan_request(OP_ALLOC, 1'b1, 12'd0);
		plan_request(OP_CLR, 1'b1, 12'hFFF);
		plan_request(OP_ALLOC, 1'b1, 12'h123);
		plan_request(OP_TEST, 1'b1, 12'hFFF);

		// Random phases: extremes and random starts, each pacing mode twice
		inode_s = '{0, 4095, 2048, 1, $urandom_range(4095), 3968, 0, $urandom_range(4095)};
		data_s = '{0, 4095, $urandom_range(4095), 0, 4000, 31, $urandom_range(4095), 1};
		for (int p = 0; p < 8; p++) begin
			plan_starts(CFG_DATA_W'(inode_s[p]), CFG_DATA_W'(data_s[p]));
			case (p % 4)
				0: plan_pace(0, 0);
				1: plan_pace(88, 0);
				2: plan_pace(0, 88);
				default: plan_pace(21, 21);
			endcase
			for (int n = 0; n < 240; n++) begin
				sel = $urandom_range(1);
				roll = $urandom_range(99);
				if (roll < 38) op = OP_ALLOC;
				else if (roll < 62) op = OP_SET;
				else if (roll < 80) op = OP_CLR;
				else op = OP_TEST;
				plan_request(op, sel[0], pick_index(sel ? data_s[p] : inode_s[p]));
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait out the stimulus, the last replies and a latency's worth of quiet
		while (!stim_done) @(posedge clk);
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (140) @(posedge clk);
		if (error_count == 0 && awaited_replies.size() == 0) begin
			$display("** bitmap_first_fit_allocator: PASSED **");
		end else begin
			$display("** bitmap_first_fit_allocator: FAILED **");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("** bitmap_first_fit_allocator: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
hdl/bffa_pkg.sv
hdl/bffa_word_ram.sv
hdl/bffa_find_zero.sv
hdl/bitmap_first_fit_allocator.sv
tb/sv/bitmap_first_fit_allocator_tb.sv
